[hw/rtl/fdt_struct_token_walker_assert.svh]
// Assertion macros for the structure block token walker.
`ifndef FDT_STRUCT_TOKEN_WALKER_ASSERT_SVH
`define FDT_STRUCT_TOKEN_WALKER_ASSERT_SVH

`ifndef SYNTHESIS
`define FDT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdt walker assertion failed");
`define FDT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fdt walker assertion failed");
`else
`define FDT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define FDT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[hw/rtl/fdt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fdt_pkg;

    localparam int WORD_W      = 32;
    localparam int SIZE_W      = 24;
    localparam int CNT_W       = 25;
    localparam int VWL_W       = 30;
    localparam int EV_W        = 3;
    localparam int KIND_W      = 3;
    localparam int PH_W        = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_DATA_W  = 136;

    localparam logic [WORD_W-1:0] TOK_PAD        = 32'h0000_0000;
    localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'h0000_0001;
    localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'h0000_0002;
    localparam logic [WORD_W-1:0] TOK_PROP       = 32'h0000_0003;
    localparam logic [WORD_W-1:0] TOK_NOP        = 32'h0000_0004;
    localparam logic [WORD_W-1:0] TOK_END        = 32'h0000_0009;

    localparam logic [KIND_W-1:0] K_SKIP     = 3'd0;
    localparam logic [KIND_W-1:0] K_BEGIN    = 3'd1;
    localparam logic [KIND_W-1:0] K_END_NODE = 3'd2;
    localparam logic [KIND_W-1:0] K_PROP     = 3'd3;
    localparam logic [KIND_W-1:0] K_END      = 3'd4;
    localparam logic [KIND_W-1:0] K_BAD      = 3'd5;

    localparam logic [PH_W-1:0] PH_TOKEN   = 3'd0;
    localparam logic [PH_W-1:0] PH_NAME    = 3'd1;
    localparam logic [PH_W-1:0] PH_LEN     = 3'd2;
    localparam logic [PH_W-1:0] PH_NAMEOFF = 3'd3;
    localparam logic [PH_W-1:0] PH_VALUE   = 3'd4;
    localparam logic [PH_W-1:0] PH_DONE    = 3'd5;

    localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EV_W-1:0] EV_BEGIN   = 3'd1;
    localparam logic [EV_W-1:0] EV_ENDNODE = 3'd2;
    localparam logic [EV_W-1:0] EV_PROP    = 3'd3;
    localparam logic [EV_W-1:0] EV_END     = 3'd4;
    localparam logic [EV_W-1:0] EV_ERROR   = 3'd5;
    localparam logic [EV_W-1:0] EV_STOP    = 3'd6;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [KIND_W-1:0] kind;
        logic              zero_byte;
    } t_item;

endpackage
`default_nettype wire

[hw/rtl/fdt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module fdt_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [fdt_pkg::WORD_W-1:0] s_axis_tdata,
    output logic                           o_item_valid,
    output fdt_pkg::t_item                 o_item,
    input  wire logic                      i_item_ready
);
    import fdt_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item.word = s_axis_tdata;
        n_item.zero_byte = (s_axis_tdata[7:0] == 8'h00) || (s_axis_tdata[15:8] == 8'h00) ||
                           (s_axis_tdata[23:16] == 8'h00) || (s_axis_tdata[31:24] == 8'h00);
        if (s_axis_tdata == TOK_BEGIN_NODE) begin
            n_item.kind = K_BEGIN;
        end else if (s_axis_tdata == TOK_END_NODE) begin
            n_item.kind = K_END_NODE;
        end else if (s_axis_tdata == TOK_PROP) begin
            n_item.kind = K_PROP;
        end else if ((s_axis_tdata == TOK_NOP) || (s_axis_tdata == TOK_PAD)) begin
            n_item.kind = K_SKIP;
        end else if (s_axis_tdata == TOK_END) begin
            n_item.kind = K_END;
        end else begin
            n_item.kind = K_BAD;
        end
    end

    assign s_axis_tready = !r_valid || i_item_ready;
    assign o_item_valid  = r_valid;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/fdt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module fdt_queue #(
    parameter int DEPTH = fdt_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire fdt_pkg::t_item i_push_item,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output fdt_pkg::t_item     o_pop_item
);
    import fdt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W_Q-1:0] r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != CNT_W_Q'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/fdt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module fdt_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fdt_pkg::SIZE_W-1:0]     i_cfg_data,
    input  wire logic                          i_item_valid,
    output logic                               o_item_ready,
    input  wire fdt_pkg::t_item                i_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [fdt_pkg::OUT_DATA_W-1:0]      o_out_data
);
    import fdt_pkg::*;

    logic [SIZE_W-1:0]     r_struct_size;
    logic [PH_W-1:0]       r_phase, n_phase;
    logic [CNT_W-1:0]      r_bc, n_bc;
    logic [WORD_W-1:0]     r_held_len, n_held_len;
    logic [WORD_W-1:0]     r_held_noff, n_held_noff;
    logic [VWL_W-1:0]      r_vwl, n_vwl;
    logic                  r_pending, n_pending;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  w_pop;
    logic [CNT_W:0]        w_sum;
    logic [CNT_W-1:0]      w_counted;
    logic [WORD_W-1:0]     w_len_m1;
    logic [EV_W-1:0]       w_ev;
    logic [WORD_W-1:0]     w_plen, w_noff, w_fval, w_bad;

    assign o_item_ready = !r_out_valid || i_out_ready;
    assign w_pop        = i_item_valid && o_item_ready;
    assign w_sum        = {1'b0, r_bc} + (CNT_W + 1)'(4);
    assign w_counted    = w_sum[CNT_W] ? '1 : w_sum[CNT_W-1:0];
    assign w_len_m1     = r_held_len - 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_bc        = r_bc;
        n_held_len  = r_held_len;
        n_held_noff = r_held_noff;
        n_vwl       = r_vwl;
        n_pending   = r_pending;
        w_ev        = EV_NONE;
        w_plen      = '0;
        w_noff      = '0;
        w_fval      = '0;
        w_bad       = '0;
        case (r_phase)
            PH_TOKEN: begin
                if (r_bc >= {1'b0, r_struct_size}) begin
                    w_ev    = EV_STOP;
                    n_phase = PH_DONE;
                end else begin
                    n_bc = w_counted;
                    case (i_item.kind)
                        K_BEGIN: begin
                            w_ev    = EV_BEGIN;
                            n_phase = PH_NAME;
                        end
                        K_END_NODE: w_ev = EV_ENDNODE;
                        K_PROP:     n_phase = PH_LEN;
                        K_SKIP:     w_ev = EV_NONE;
                        K_END: begin
                            w_ev    = EV_END;
                            n_phase = PH_DONE;
                        end
                        default: begin
                            w_ev    = EV_ERROR;
                            w_bad   = i_item.word;
                            n_phase = PH_DONE;
                        end
                    endcase
                end
            end
            PH_NAME: begin
                n_bc = w_counted;
                if (i_item.zero_byte) begin
                    n_phase = PH_TOKEN;
                end
            end
            PH_LEN: begin
                n_bc       = w_counted;
                n_held_len = i_item.word;
                n_phase    = PH_NAMEOFF;
            end
            PH_NAMEOFF: begin
                n_bc        = w_counted;
                n_held_noff = i_item.word;
                if (r_held_len != '0) begin
                    n_pending = 1'b1;
                    n_phase   = PH_VALUE;
                end else begin
                    n_phase = PH_TOKEN;
                end
            end
            PH_VALUE: begin
                n_bc = w_counted;
                if (r_pending) begin
                    n_pending = 1'b0;
                    w_ev      = EV_PROP;
                    w_plen    = r_held_len;
                    w_noff    = r_held_noff;
                    w_fval    = i_item.word;
                    n_vwl     = w_len_m1[WORD_W-1:2];
                end else if (r_vwl != '0) begin
                    n_vwl = r_vwl - 1'b1;
                end
                if (n_vwl == '0) begin
                    n_phase = PH_TOKEN;
                end
            end
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_DONE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_struct_size <= '0;
            r_phase       <= PH_TOKEN;
            r_bc          <= '0;
            r_held_len    <= '0;
            r_held_noff   <= '0;
            r_vwl         <= '0;
            r_pending     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_struct_size <= i_cfg_data;
            end
            if (w_pop) begin
                r_phase     <= n_phase;
                r_bc        <= n_bc;
                r_held_len  <= n_held_len;
                r_held_noff <= n_held_noff;
                r_vwl       <= n_vwl;
                r_pending   <= n_pending;
            end
            if (o_item_ready) begin
                r_out_valid <= i_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_data <= {5'b0, w_bad, w_fval, w_noff, w_plen, w_ev};
        end
    end

endmodule
`default_nettype wire

[hw/rtl/fdt_struct_token_walker.sv]
// An accepted item passes the front register, the queue and the back output register.
// Throughput: one item per cycle unless m_axis stalls; walker updates once per item.
// Output stalls back up through a small queue, then the classify stage.
// Reset (synchronous, active low) clears the walk state, counters and the
// size register to zero and empties all stages; payload registers hold.
`timescale 1ns / 1ps
`default_nettype none
`include "fdt_struct_token_walker_assert.svh"
module fdt_struct_token_walker #(
    parameter int Q_DEPTH = fdt_pkg::QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fdt_pkg::SIZE_W-1:0]     i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // word[31:0]
    input  wire logic [fdt_pkg::WORD_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // event_res[2:0], prop_length[34:3], name_offset[66:35],
    // first_value[98:67], bad_token[130:99], zero[135:131]
    output logic [fdt_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import fdt_pkg::*;

    logic  w_fr_valid, w_fr_ready;
    t_item w_fr_item;
    logic  w_q_valid, w_q_ready;
    t_item w_q_item;
    logic [EV_W-1:0]   w_out_ev;
    logic [WORD_W-1:0] w_out_plen, w_out_noff, w_out_fval, w_out_bad;
    logic              w_is_err, w_is_prop, w_prop_clear, w_plen_zero;

    fdt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_item_valid  (w_fr_valid),
        .o_item        (w_fr_item),
        .i_item_ready  (w_fr_ready)
    );

    fdt_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fr_valid),
        .o_push_ready (w_fr_ready),
        .i_push_item  (w_fr_item),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_item   (w_q_item)
    );

    fdt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (w_q_valid),
        .o_item_ready (w_q_ready),
        .i_item       (w_q_item),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata)
    );

    assign w_out_ev   = m_axis_tdata[2:0];
    assign w_out_plen = m_axis_tdata[34:3];
    assign w_out_noff = m_axis_tdata[66:35];
    assign w_out_fval = m_axis_tdata[98:67];
    assign w_out_bad  = m_axis_tdata[130:99];

    assign w_is_err     = (w_out_ev == EV_ERROR);
    assign w_is_prop    = (w_out_ev == EV_PROP);
    assign w_plen_zero  = (w_out_plen == '0);
    assign w_prop_clear = w_plen_zero && (w_out_noff == '0) && (w_out_fval == '0);

    `FDT_ASSERT_IMPLY(a_bad_only_on_error, i_clk, i_rst_n, m_axis_tvalid && !w_is_err, w_out_bad == '0)
    `FDT_ASSERT_IMPLY(a_prop_fields_idle, i_clk, i_rst_n, m_axis_tvalid && !w_is_prop, w_prop_clear)
    `FDT_ASSERT_NEVER(a_no_empty_prop, i_clk, i_rst_n, m_axis_tvalid && w_is_prop && w_plen_zero)

endmodule
`default_nettype wire
